### design/rlptd_pkg.sv
`default_nettype none

package rlptd_pkg;

    // Defaults and limits
    localparam int LEN_BITS_DEFAULT = 32;
    localparam int MAX_NUMBER_BYTES = 32;
    localparam int ADDRESS_BYTES    = 20;
    localparam int SIG_RS_BYTES     = 32;
    localparam int SIG_V_BYTES      = 1;
    localparam int PADDR_W          = 3;

    // Header byte boundaries
    localparam logic [7:0] SHORT_STR_BASE = 8'h80;
    localparam logic [7:0] LONG_STR_BASE  = 8'hb8;
    localparam logic [7:0] LIST_BASE      = 8'hc0;
    localparam logic [7:0] LONG_LIST_BASE = 8'hf8;

    // Field numbers
    localparam logic [3:0] FLD_NONCE     = 4'd0;
    localparam logic [3:0] FLD_GAS_PRICE = 4'd1;
    localparam logic [3:0] FLD_GAS_LIMIT = 4'd2;
    localparam logic [3:0] FLD_TO        = 4'd3;
    localparam logic [3:0] FLD_VALUE     = 4'd4;
    localparam logic [3:0] FLD_DATA      = 4'd5;
    localparam logic [3:0] FLD_V         = 4'd6;
    localparam logic [3:0] FLD_R         = 4'd7;
    localparam logic [3:0] FLD_S         = 4'd8;

    // Configuration register addresses
    localparam logic [PADDR_W-1:0] ADDR_CHECK_SIG = PADDR_W'(0);

    typedef enum logic [2:0] {
        E_OK        = 3'd0,
        E_NOT_LIST  = 3'd1,
        E_NUM_LONG  = 3'd2,
        E_BAD_ADDR  = 3'd3,
        E_BAD_SIG   = 3'd4,
        E_NESTED    = 3'd5,
        E_LEN_OVF   = 3'd6
    } t_err;

endpackage

`default_nettype wire

### design/rlptd_in_if.sv
`default_nettype none

interface rlptd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

### design/rlptd_out_if.sv
`default_nettype none

interface rlptd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic [3:0] field_index;
    logic       field_end;
    logic       tx_end;
    logic [2:0] error_code;

    modport source (
        output valid, output data_byte, output has_byte, output field_index,
        output field_end, output tx_end, output error_code, input ready
    );
    modport sink (
        input valid, input data_byte, input has_byte, input field_index,
        input field_end, input tx_end, input error_code, output ready
    );
endinterface

`default_nettype wire

### design/rlp_transaction_decoder.sv
// A result request is registered and presented in the cycle after the byte that causes it.
// Throughput: one stream byte per cycle; the header/length state update and the output
// register bound the rate, stalled only by output back-pressure.
// Reset (i_rst_n, synchronous, active low): expect a list header, clear field and
// length counters, drop any pending result, clear the signature check enable.
`default_nettype none

module rlp_transaction_decoder
    import rlptd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    rlptd_in_if.sink                 i_in,
    rlptd_out_if.source              o_out,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    typedef enum logic [2:0] {
        P_LIST_HDR  = 3'd0,
        P_LIST_LEN  = 3'd1,
        P_FIELD_HDR = 3'd2,
        P_FIELD_LEN = 3'd3,
        P_PAYLOAD   = 3'd4,
        P_HUNT      = 3'd5
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [3:0]          r_len_left, n_len_left;
    logic [3:0]          r_field, n_field;
    logic [LEN_BITS-1:0] r_payload, n_payload;
    logic                r_check_sig;

    logic                r_out_valid;
    logic [7:0]          r_data_byte;
    logic                r_has_byte;
    logic [3:0]          r_field_index;
    logic                r_field_end;
    logic                r_tx_end;
    t_err                r_error_code;

    logic                in_fire;
    logic [7:0]          b;
    logic                emit;
    logic [7:0]          res_byte;
    logic                res_has;
    logic                res_fend;
    logic                res_tend;
    t_err                res_err;

    logic                do_list, do_start, do_fin, do_fail;
    logic                fin_has;
    logic [7:0]          fin_byte;
    t_err                fail_err, start_err, single_err;
    logic [LEN_BITS-1:0] start_len;
    logic [LEN_BITS-1:0] shifted;
    logic [3:0]          len_dec;

    // Length rule for a field once its length is known
    function automatic t_err length_error(input logic [3:0] f, input logic [LEN_BITS-1:0] len,
                                          input logic chk);
        t_err e;
        e = E_OK;
        if ((f == FLD_NONCE || f == FLD_GAS_PRICE || f == FLD_GAS_LIMIT || f == FLD_VALUE)
            && len > LEN_BITS'(MAX_NUMBER_BYTES)) begin
            e = E_NUM_LONG;
        end else if (f == FLD_TO && len != LEN_BITS'(ADDRESS_BYTES)) begin
            e = E_BAD_ADDR;
        end else if (chk && f == FLD_V && len != LEN_BITS'(SIG_V_BYTES)) begin
            e = E_BAD_SIG;
        end else if (chk && (f == FLD_R || f == FLD_S) && len != LEN_BITS'(SIG_RS_BYTES)) begin
            e = E_BAD_SIG;
        end
        return e;
    endfunction

    // Handshake: take a new request while the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;

    assign shifted    = LEN_BITS'({r_payload, b});
    assign len_dec    = (r_len_left != 4'd0) ? r_len_left - 4'd1 : 4'd0;
    assign single_err = length_error(r_field, LEN_BITS'(1), r_check_sig);

    // Decode one stream byte
    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_field    = r_field;
        n_payload  = r_payload;
        do_list    = 1'b0;
        do_start   = 1'b0;
        do_fin     = 1'b0;
        do_fail    = 1'b0;
        fin_has    = 1'b0;
        fin_byte   = 8'd0;
        fail_err   = E_OK;
        start_len  = '0;
        emit       = 1'b0;
        res_byte   = 8'd0;
        res_has    = 1'b0;
        res_fend   = 1'b0;
        res_tend   = 1'b0;
        res_err    = E_OK;

        case (r_phase)
            P_LIST_HDR: begin
                if (b < LIST_BASE) begin
                    do_fail  = 1'b1;
                    fail_err = E_NOT_LIST;
                end else begin
                    do_list = 1'b1;
                end
            end
            P_HUNT: begin
                do_list = (b >= LIST_BASE);
            end
            P_LIST_LEN: begin
                n_len_left = len_dec;
                if (len_dec == 4'd0) begin
                    n_phase = P_FIELD_HDR;
                end
            end
            P_FIELD_HDR: begin
                if (b >= LIST_BASE) begin
                    do_fail  = 1'b1;
                    fail_err = E_NESTED;
                end else if (b < SHORT_STR_BASE) begin
                    if (single_err != E_OK) begin
                        do_fail  = 1'b1;
                        fail_err = single_err;
                    end else begin
                        do_fin   = 1'b1;
                        fin_has  = 1'b1;
                        fin_byte = b;
                    end
                end else if (b < LONG_STR_BASE) begin
                    do_start  = 1'b1;
                    start_len = LEN_BITS'(b - SHORT_STR_BASE);
                end else begin
                    n_len_left = {1'b0, b[2:0]} + 4'd1;
                    n_payload  = '0;
                    n_phase    = P_FIELD_LEN;
                end
            end
            P_FIELD_LEN: begin
                if (r_payload[LEN_BITS-1 -: 8] != 8'd0) begin
                    do_fail  = 1'b1;
                    fail_err = E_LEN_OVF;
                end else begin
                    n_payload  = shifted;
                    n_len_left = len_dec;
                    if (len_dec == 4'd0) begin
                        do_start  = 1'b1;
                        start_len = shifted;
                    end
                end
            end
            P_PAYLOAD: begin
                if (r_payload <= LEN_BITS'(1)) begin
                    do_fin   = 1'b1;
                    fin_has  = 1'b1;
                    fin_byte = b;
                end else begin
                    n_payload = r_payload - LEN_BITS'(1);
                    emit      = 1'b1;
                    res_byte  = b;
                    res_has   = 1'b1;
                end
            end
            default: begin
                n_phase = P_HUNT;
            end
        endcase

        start_err = length_error(r_field, start_len, r_check_sig);

        // Field length known: check, then enter payload or close an empty field
        if (do_start) begin
            if (start_err != E_OK) begin
                do_fail  = 1'b1;
                fail_err = start_err;
            end else if (start_len == '0) begin
                do_fin = 1'b1;
            end else begin
                n_payload = start_len;
                n_phase   = P_PAYLOAD;
            end
        end

        // Open a new transaction
        if (do_list) begin
            n_field   = FLD_NONCE;
            n_payload = '0;
            if (b >= LONG_LIST_BASE) begin
                n_len_left = {1'b0, b[2:0]} + 4'd1;
                n_phase    = P_LIST_LEN;
            end else begin
                n_len_left = 4'd0;
                n_phase    = P_FIELD_HDR;
            end
        end

        // Close the current field and advance
        if (do_fin) begin
            emit      = 1'b1;
            res_byte  = fin_byte;
            res_has   = fin_has;
            res_fend  = 1'b1;
            res_tend  = (r_field >= FLD_S);
            n_payload = '0;
            if (r_field >= FLD_S) begin
                n_field = FLD_NONCE;
                n_phase = P_LIST_HDR;
            end else begin
                n_field = r_field + 4'd1;
                n_phase = P_FIELD_HDR;
            end
        end

        // Flag the error and hunt for the next list header
        if (do_fail) begin
            emit       = 1'b1;
            res_byte   = 8'd0;
            res_has    = 1'b0;
            res_fend   = 1'b0;
            res_tend   = 1'b0;
            res_err    = fail_err;
            n_phase    = P_HUNT;
            n_field    = FLD_NONCE;
            n_len_left = 4'd0;
            n_payload  = '0;
        end
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_LIST_HDR;
            r_len_left  <= 4'd0;
            r_field     <= FLD_NONCE;
            r_payload   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase    <= n_phase;
                r_len_left <= n_len_left;
                r_field    <= n_field;
                r_payload  <= n_payload;
            end
            if (in_fire && emit) begin
                r_out_valid   <= 1'b1;
                r_data_byte   <= res_byte;
                r_has_byte    <= res_has;
                r_field_index <= r_field;
                r_field_end   <= res_fend;
                r_tx_end      <= res_tend;
                r_error_code  <= res_err;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.data_byte   = r_data_byte;
    assign o_out.has_byte    = r_has_byte;
    assign o_out.field_index = r_field_index;
    assign o_out.field_end   = r_field_end;
    assign o_out.tx_end      = r_tx_end;
    assign o_out.error_code  = r_error_code;

    // Configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_sig <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CHECK_SIG) begin
            r_check_sig <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CHECK_SIG) ? {31'd0, r_check_sig} : 32'd0;

endmodule

`default_nettype wire

### test/tb_rlp_transaction_decoder.sv
`timescale 1ns / 100ps

module tb_rlp_transaction_decoder;
    import rlptd_pkg::*;

    localparam int LEN_BITS        = LEN_BITS_DEFAULT;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int STIM_PHASES     = 4;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_REPORTS     = 25;

    typedef enum logic [2:0] {
        ST_LIST_HDR,
        ST_LIST_LEN,
        ST_FIELD_HDR,
        ST_FIELD_LEN,
        ST_PAYLOAD,
        ST_HUNT
    } dec_state_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic [3:0] field_index;
        logic       field_end;
        logic       tx_end;
        t_err       error_code;
    } field_result_t;

    // Decoder prediction and result checking
    class rlp_scoreboard;
        field_result_t expected_q[$];
        int            fail_count;
        int            result_count;
        int            tx_count;
        int            error_count;
        dec_state_t    state;
        logic [3:0]    len_left;
        logic [3:0]    field;
        logic [63:0]   payload_left;
        bit            sig_check;

        function new();
            state        = ST_LIST_HDR;
            len_left     = '0;
            field        = '0;
            payload_left = '0;
            sig_check    = 1'b0;
            fail_count   = 0;
            result_count = 0;
            tx_count     = 0;
            error_count  = 0;
        endfunction

        function void set_signature_check(bit v);
            sig_check = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void emit(logic [7:0] b, logic has, logic fend, logic tend, t_err err);
            field_result_t r;
            r.data_byte   = b;
            r.has_byte    = has;
            r.field_index = field;
            r.field_end   = fend;
            r.tx_end      = tend;
            r.error_code  = err;
            expected_q.push_back(r);
        endfunction

        // Report the error, then drop bytes until the next list header
        function void flag(t_err err);
            emit(8'h00, 1'b0, 1'b0, 1'b0, err);
            state        = ST_HUNT;
            field        = '0;
            len_left     = '0;
            payload_left = '0;
        endfunction

        function t_err length_fault(logic [3:0] f, logic [63:0] len);
            if ((f == FLD_NONCE || f == FLD_GAS_PRICE || f == FLD_GAS_LIMIT ||
                 f == FLD_VALUE) && len > MAX_NUMBER_BYTES)
                return E_NUM_LONG;
            if (f == FLD_TO && len != ADDRESS_BYTES)
                return E_BAD_ADDR;
            if (sig_check) begin
                if (f == FLD_V && len != SIG_V_BYTES)
                    return E_BAD_SIG;
                if ((f == FLD_R || f == FLD_S) && len != SIG_RS_BYTES)
                    return E_BAD_SIG;
            end
            return E_OK;
        endfunction

        // Emit the last result of a field and advance to the next one
        function void close_field(logic [7:0] b, logic has);
            logic last;
            last = (field >= FLD_S);
            emit(b, has, 1'b1, last, E_OK);
            payload_left = '0;
            if (last) begin
                field = '0;
                state = ST_LIST_HDR;
            end else begin
                field = field + 4'd1;
                state = ST_FIELD_HDR;
            end
        endfunction

        function void open_payload(logic [63:0] len);
            t_err e;
            e = length_fault(field, len);
            if (e != E_OK) begin
                flag(e);
            end else if (len == 0) begin
                close_field(8'h00, 1'b0);
            end else begin
                payload_left = len;
                state        = ST_PAYLOAD;
            end
        endfunction

        function void take_list_header(logic [7:0] b);
            field        = '0;
            payload_left = '0;
            if (b >= LONG_LIST_BASE) begin
                len_left = 4'(b - (LONG_LIST_BASE - 8'd1));
                state    = ST_LIST_LEN;
            end else begin
                len_left = '0;
                state    = ST_FIELD_HDR;
            end
        endfunction

        // Advance the predicted decoder by one accepted stream byte
        function void note_byte(logic [7:0] b);
            t_err e;
            case (state)
                ST_LIST_HDR: begin
                    if (b < LIST_BASE)
                        flag(E_NOT_LIST);
                    else
                        take_list_header(b);
                end
                ST_HUNT: begin
                    if (b >= LIST_BASE)
                        take_list_header(b);
                end
                ST_LIST_LEN: begin
                    if (len_left > 0)
                        len_left = len_left - 4'd1;
                    if (len_left == 0)
                        state = ST_FIELD_HDR;
                end
                ST_FIELD_HDR: begin
                    if (b >= LIST_BASE) begin
                        flag(E_NESTED);
                    end else if (b < SHORT_STR_BASE) begin
                        e = length_fault(field, 64'd1);
                        if (e != E_OK)
                            flag(e);
                        else
                            close_field(b, 1'b1);
                    end else if (b < LONG_STR_BASE) begin
                        open_payload(64'(b - SHORT_STR_BASE));
                    end else begin
                        len_left     = 4'(b - (LONG_STR_BASE - 8'd1));
                        payload_left = '0;
                        state        = ST_FIELD_LEN;
                    end
                end
                ST_FIELD_LEN: begin
                    if ((payload_left >> (LEN_BITS - 8)) != 0) begin
                        flag(E_LEN_OVF);
                    end else begin
                        payload_left = (payload_left << 8) | 64'(b);
                        if (len_left > 0)
                            len_left = len_left - 4'd1;
                        if (len_left == 0)
                            open_payload(payload_left);
                    end
                end
                ST_PAYLOAD: begin
                    if (payload_left <= 1) begin
                        close_field(b, 1'b1);
                    end else begin
                        payload_left = payload_left - 64'd1;
                        emit(b, 1'b1, 1'b0, 1'b0, E_OK);
                    end
                end
                default: state = ST_HUNT;
            endcase
        endfunction

        // Compare one result request against the oldest prediction
        function void check_result(field_result_t got);
            field_result_t want;
            result_count++;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, got byte %02h has %0b ",
                             $time, got.data_byte, got.has_byte,
                             "field %0d fend %0b tend %0b err %0d", got.field_index,
                             got.field_end, got.tx_end, got.error_code);
                return;
            end
            want = expected_q.pop_front();
            if (want.tx_end)
                tx_count++;
            if (want.error_code != E_OK)
                error_count++;
            if (got.data_byte !== want.data_byte || got.has_byte !== want.has_byte ||
                got.field_index !== want.field_index || got.field_end !== want.field_end ||
                got.tx_end !== want.tx_end || got.error_code !== want.error_code) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result mismatch: expected byte %02h has %0b field %0d ",
                             $time, want.data_byte, want.has_byte, want.field_index,
                             "fend %0b tend %0b err %0d, got byte %02h has %0b field %0d ",
                             want.field_end, want.tx_end, want.error_code,
                             got.data_byte, got.has_byte, got.field_index,
                             "fend %0b tend %0b err %0d",
                             got.field_end, got.tx_end, got.error_code);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    rlptd_in_if  in_if ();
    rlptd_out_if out_if ();

    rlp_scoreboard sb;

    logic [7:0] byte_stream[$];
    bit         open_tx;
    int         bytes_sent;
    int         in_mode;
    int         in_count;

    rlp_transaction_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // Idle pattern: none, uniform, or rare long gaps
    function automatic int draw_wait(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    function automatic void put_byte(int b);
        byte_stream.push_back(8'(b));
    endfunction

    // Encode one string field: single byte, short or long form
    function automatic void push_field(int len, bit with_payload);
        int form;
        int n_min;
        int n;
        form = $urandom_range(0, 2);
        if (len == 1 && form == 0) begin
            put_byte($urandom_range(0, SHORT_STR_BASE - 1));
            return;
        end
        if (len <= int'(LONG_STR_BASE - SHORT_STR_BASE) && form <= 1) begin
            put_byte(SHORT_STR_BASE + len);
        end else begin
            n_min = 1;
            while ((len >> (8 * n_min)) != 0)
                n_min++;
            // Allow leading zero length bytes
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(n_min, 8) : n_min;
            put_byte(LONG_STR_BASE - 1 + n);
            for (int i = n - 1; i >= 0; i--)
                put_byte((i < 4) ? ((len >> (8 * i)) & 8'hff) : 0);
        end
        if (with_payload)
            repeat (len) put_byte($urandom_range(0, 255));
    endfunction

    function automatic int good_len(logic [3:0] f, bit chk);
        case (f)
            FLD_TO:   return ADDRESS_BYTES;
            FLD_DATA: return ($urandom_range(0, 19) == 0) ? $urandom_range(56, 300)
                                                          : $urandom_range(0, 24);
            FLD_V:    return chk ? SIG_V_BYTES : $urandom_range(0, 3);
            FLD_R, FLD_S: return chk ? SIG_RS_BYTES : $urandom_range(0, 33);
            default:  return ($urandom_range(0, 7) == 0) ? MAX_NUMBER_BYTES
                                                         : $urandom_range(0, 6);
        endcase
    endfunction

    function automatic void push_list_header();
        int n;
        if ($urandom_range(0, 1) == 0) begin
            put_byte($urandom_range(LIST_BASE, LONG_LIST_BASE - 1));
        end else begin
            n = $urandom_range(1, 8);
            put_byte(LONG_LIST_BASE - 1 + n);
            repeat (n) put_byte($urandom_range(0, 255));
        end
    endfunction

    // Push a field header that must be flagged; the error lands on its last byte
    function automatic void push_fault(logic [3:0] f, bit chk);
        int pick;
        int len;
        pick = $urandom_range(0, 2);
        if (pick == 1) begin
            // Length overflow: nonzero top byte, flagged on the fifth length byte
            put_byte(LONG_STR_BASE - 1 + $urandom_range(5, 8));
            put_byte($urandom_range(1, 255));
            repeat (4) put_byte($urandom_range(0, 255));
        end else if (pick == 2 && f != FLD_DATA && (chk || f < FLD_V)) begin
            if (f == FLD_TO) begin
                do len = $urandom_range(0, 40); while (len == ADDRESS_BYTES);
            end else if (f == FLD_V) begin
                do len = $urandom_range(0, 40); while (len == SIG_V_BYTES);
            end else if (f >= FLD_R) begin
                do len = $urandom_range(0, 40); while (len == SIG_RS_BYTES);
            end else begin
                len = $urandom_range(MAX_NUMBER_BYTES + 1, 60);
            end
            push_field(len, 1'b0);
        end else begin
            put_byte($urandom_range(LIST_BASE, 8'hff));
        end
    endfunction

    // Build one transaction; return the number of bytes the block just drops
    function automatic int build_transaction(bit chk);
        int kind;
        int n;
        int fe;
        kind = $urandom_range(0, open_tx ? 91 : 99);
        open_tx = 1'b0;
        if (kind >= 92) begin
            n = $urandom_range(1, 4);
            repeat (n) put_byte($urandom_range(0, LIST_BASE - 1));
            return n - 1;
        end
        push_list_header();
        if (kind < 55) begin
            for (int f = FLD_NONCE; f <= FLD_S; f++)
                push_field(good_len(4'(f), chk), 1'b1);
            return 0;
        end
        if (kind < 85) begin
            fe = $urandom_range(FLD_NONCE, FLD_S);
            for (int f = FLD_NONCE; f < fe; f++)
                push_field(good_len(4'(f), chk), 1'b1);
            push_fault(4'(fe), chk);
            n = $urandom_range(0, 3);
            repeat (n) put_byte($urandom_range(0, LIST_BASE - 1));
            return n;
        end
        // Cut short after whole fields; the next list header lands on a field header
        n = $urandom_range(0, FLD_S);
        for (int f = FLD_NONCE; f < n; f++)
            push_field(good_len(4'(f), chk), 1'b1);
        open_tx = 1'b1;
        return 0;
    endfunction

    // Drive the queued bytes as input requests
    task automatic send_stream();
        int gap;
        foreach (byte_stream[k]) begin
            if (in_count % 40 == 0)
                in_mode = $urandom_range(0, 2);
            in_count++;
            gap = draw_wait(in_mode);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_if.valid   <= 1'b1;
            in_if.in_byte <= byte_stream[k];
            do @(posedge i_clk); while (!in_if.ready);
            sb.note_byte(byte_stream[k]);
            bytes_sent++;
        end
        byte_stream.delete();
    endtask

    // Hold input low until every predicted result has arrived, then settle
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input bit is_write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_CHECK_SIG;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_signature_check(bit v);
        logic [31:0] rd;
        apb_transfer(1'b1, 32'(v), rd);
        sb.set_signature_check(v);
        apb_transfer(1'b0, 32'h0, rd);
        if (rd !== 32'(v)) begin
            sb.fail_count++;
            $display("%0t: register readback mismatch: expected %08h, got %08h",
                     $time, 32'(v), rd);
        end
    endtask

    // Result side: random back-pressure
    initial begin
        int mode;
        int cnt;
        int gap;
        out_if.ready <= 1'b0;
        cnt = 0;
        mode = 0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (cnt % 40 == 0)
                mode = $urandom_range(0, 2);
            cnt++;
            gap = draw_wait(mode);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    // Check each accepted result request
    always @(posedge i_clk) begin
        field_result_t got;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.data_byte   = out_if.data_byte;
            got.has_byte    = out_if.has_byte;
            got.field_index = out_if.field_index;
            got.field_end   = out_if.field_end;
            got.tx_end      = out_if.tx_end;
            got.error_code  = t_err'(out_if.error_code);
            sb.check_result(got);
        end
    end

    // Abort when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) || psel === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int dropped;
        int phase_items;
        sb = new();
        open_tx    = 1'b0;
        bytes_sent = 0;
        in_mode    = 0;
        in_count   = 0;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one case per error class but the signature error, with checking at its reset value
        put_byte(8'h00);                                     // not a list
        put_byte(LONG_LIST_BASE);
        put_byte(8'hff);
        put_byte(LIST_BASE);                                 // nested list at nonce
        put_byte(LIST_BASE);
        put_byte(8'h7f);                                     // single-byte nonce
        put_byte(SHORT_STR_BASE);                            // empty gas price
        put_byte(LONG_STR_BASE);
        put_byte(MAX_NUMBER_BYTES + 1);                      // gas limit too long
        put_byte(LIST_BASE + 1);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(SHORT_STR_BASE + ADDRESS_BYTES - 1);        // short address
        put_byte(LONG_LIST_BASE - 1);
        put_byte(LIST_BASE - 1);                             // eight length bytes
        put_byte(8'h01);
        repeat (4) put_byte(8'h00);                          // overflow on the fifth
        send_stream();
        drain();

        // Random phases, alternating the signature length check
        for (int p = 0; p < STIM_PHASES; p++) begin
            set_signature_check(p % 2 == 0);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                dropped = build_transaction(p % 2 == 0);
                phase_items += byte_stream.size() - dropped;
                send_stream();
            end
            drain();
        end

        $display("Sent %0d stream bytes; checked %0d results: %0d complete transactions, ",
                 bytes_sent, sb.result_count, sb.tx_count,
                 "%0d error flags", sb.error_count);
        $display("Signature length check toggled across %0d random phases", STIM_PHASES);
        if (sb.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### rlp_transaction_decoder.f
design/rlptd_pkg.sv
design/rlptd_in_if.sv
design/rlptd_out_if.sv
design/rlp_transaction_decoder.sv
test/tb_rlp_transaction_decoder.sv
